// ----- hdl/obfv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_pkg
// Shared types, widths and helpers of the orthonormal basis generator.
// ----------------------------------------------------------------------------
package obfv_pkg;

  localparam int IN_W          = 24;  // forward vector component width
  localparam int OUT_W         = 24;  // unit vector component width
  localparam int LIMIT_W       = 23;  // collinear limit register width
  localparam int NORM_W        = 24;  // magnitude width after block scaling
  localparam int ROOT_W        = 25;  // width of the integer square root
  localparam int SUMSQ_W       = 50;  // width of the sum of three squares
  localparam int RAW_W         = 25;  // first vector to normalize, signed
  localparam int FRAC_BITS_DEF = 22;  // default number of fraction bits

  typedef struct packed {
    logic signed [IN_W-1:0] fwd_x;
    logic signed [IN_W-1:0] fwd_y;
    logic signed [IN_W-1:0] fwd_z;
  } fwd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] left_y;
    logic signed [OUT_W-1:0] left_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
    logic                    used_y_reference;
    logic                    degenerate;
  } basis_t;

  // Status that leaves a normalizer together with its result.
  typedef struct packed {
    logic valid;
    logic deg;
  } norm_ctl_t;

  // Pipeline depth of one normalizer for a signed input width iw.
  function automatic int norm_depth(int iw, int frac);
    return $clog2(iw) + frac + 1 + 30;
  endfunction

endpackage

// ----- hdl/obfv_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfv_norm
// Pipelined normalizer: scales a signed integer 3-vector to unit length with
// round-to-nearest, one vector per cycle, carrying a side tag along.
// ----------------------------------------------------------------------------
module obfv_norm import obfv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IW        = RAW_W,
  parameter int TW        = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [2:0][IW-1:0]          vec_i,
  input  logic [TW-1:0]               tag_i,
  output norm_ctl_t                   ctl_o,
  output logic [TW-1:0]               tag_o,
  output logic [2:0][OUT_W-1:0]       unit_o,
  output logic [2:0][FRAC_BITS+1:0]   full_o
);

  localparam int QW     = FRAC_BITS + 1;
  localparam int NSH    = $clog2(IW);
  localparam int NW     = NORM_W + FRAC_BITS + 1;
  localparam int RW     = SUMSQ_W + 1;
  localparam int SQ_W   = 2 * NORM_W;
  localparam int EW     = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
  localparam int DEPTH  = norm_depth(IW, FRAC_BITS);
  localparam int P_SQ   = NSH + 1;
  localparam int P_RT0  = NSH + 3;
  localparam int P_NUM  = P_RT0 + ROOT_W;
  localparam int P_DV0  = P_NUM + 1;
  localparam int P_OUT  = P_DV0 + QW;
  localparam int SDW    = TW + 4;
  localparam logic signed [FRAC_BITS+1:0] UNIT_P = (FRAC_BITS + 2)'(1) << FRAC_BITS;
  localparam logic signed [FRAC_BITS+1:0] UNIT_N = -UNIT_P;

  // Side information per stage: {tag, sign of each component, zero vector}.
  logic                       vld_q  [DEPTH];
  logic [SDW-1:0]             side_q [DEPTH];

  logic [2:0][IW-1:0]         mag0_d;
  logic [2:0]                 neg0_d;
  logic [2:0][IW-1:0]         shv_q  [NSH+1];
  logic [2:0][NORM_W-1:0]     top_nm;
  logic [2:0][NORM_W-1:0]     nm_q   [ROOT_W+2];
  logic [2:0][SQ_W-1:0]       sq_q;
  logic [SUMSQ_W-1:0]         sum_q;
  logic [SUMSQ_W-1:0]         rn_q   [ROOT_W];
  logic [RW-1:0]              rr_q   [ROOT_W];
  logic [ROOT_W-1:0]          len_q;
  logic [2:0][NW-1:0]         num_q;
  logic [2:0][NW-1:0]         dr_q   [QW];
  logic [2:0][QW-1:0]         dq_q   [QW];
  logic [ROOT_W-1:0]          dl_q   [QW];
  logic [2:0][OUT_W-1:0]      unit_d, unit_q;
  logic [2:0][FRAC_BITS+1:0]  full_d, full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage 0: magnitudes and signs.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg0_d[c] = vec_i[c][IW-1];
      mag0_d[c] = vec_i[c][IW-1] ? (~vec_i[c] + IW'(1)) : vec_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= {tag_i, neg0_d, (vec_i == '0)};
    for (int k = 1; k < DEPTH; k++) side_q[k] <= side_q[k-1];
    shv_q[0] <= mag0_d;
  end

  // Common left shift until the largest magnitude has its top bit set.
  for (genvar s = 1; s <= NSH; s++) begin : g_shift
    localparam int SH = 1 << (NSH - s);
    logic [IW-1:0] ow;
    logic          hit;
    assign ow  = shv_q[s-1][0] | shv_q[s-1][1] | shv_q[s-1][2];
    assign hit = (ow[IW-1 -: SH] == '0);
    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 3; c++) begin
        shv_q[s][c] <= hit ? (shv_q[s-1][c] << SH) : shv_q[s-1][c];
      end
    end
  end

  // The top bits truncate a right shift and complete a left shift.
  always_comb begin
    for (int c = 0; c < 3; c++) top_nm[c] = shv_q[NSH][c][IW-1 -: NORM_W];
  end

  always_ff @(posedge clk_i) begin
    nm_q[0] <= top_nm;
    for (int k = 1; k < ROOT_W + 2; k++) nm_q[k] <= nm_q[k-1];
    for (int c = 0; c < 3; c++) sq_q[c] <= SQ_W'(top_nm[c]) * SQ_W'(top_nm[c]);
    sum_q <= SUMSQ_W'(sq_q[0]) + SUMSQ_W'(sq_q[1]) + SUMSQ_W'(sq_q[2]);
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - k));
    logic [SUMSQ_W-1:0] n_in;
    logic [RW-1:0]      r_in;
    logic [RW-1:0]      trial;
    logic               take;
    if (k == 0) begin : g_first
      assign n_in = sum_q;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = rn_q[k-1];
      assign r_in = rr_q[k-1];
    end
    assign trial = r_in + BIT;
    assign take  = (RW'(n_in) >= trial);
    always_ff @(posedge clk_i) begin
      rn_q[k] <= take ? (n_in - SUMSQ_W'(trial)) : n_in;
      rr_q[k] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
    end
  end

  // Rounded dividend: magnitude scaled to the fraction plus half the length.
  always_ff @(posedge clk_i) begin
    len_q <= rr_q[ROOT_W-1][ROOT_W-1:0];
    for (int c = 0; c < 3; c++) begin
      num_q[c] <= (NW'(nm_q[ROOT_W+1][c]) << FRAC_BITS)
                + NW'(rr_q[ROOT_W-1][ROOT_W-1:1]);
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes.
  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int SI = QW - 1 - t;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [ROOT_W-1:0]  len_in;
    logic [NW-1:0]      dvs;
    logic [2:0]         ge;
    if (t == 0) begin : g_first
      assign rem_in = num_q;
      assign quo_in = '0;
      assign len_in = len_q;
    end else begin : g_next
      assign rem_in = dr_q[t-1];
      assign quo_in = dq_q[t-1];
      assign len_in = dl_q[t-1];
    end
    assign dvs = NW'(len_in) << SI;
    always_comb begin
      for (int c = 0; c < 3; c++) ge[c] = (rem_in[c] >= dvs);
    end
    always_ff @(posedge clk_i) begin
      dl_q[t] <= len_in;
      for (int c = 0; c < 3; c++) begin
        dr_q[t][c] <= ge[c] ? (rem_in[c] - dvs) : rem_in[c];
        dq_q[t][c] <= quo_in[c] | (QW'(ge[c]) << SI);
      end
    end
  end

  // Sign restore; a zero vector gives zeros.
  always_comb begin
    logic [EW-1:0] qe;
    logic [EW-1:0] val;
    for (int c = 0; c < 3; c++) begin
      qe  = EW'(dq_q[QW-1][c]);
      val = side_q[P_OUT-1][1+c] ? -qe : qe;
      if (side_q[P_OUT-1][0]) begin
        val = '0;
      end
      unit_d[c] = val[OUT_W-1:0];
      full_d[c] = val[QW:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    full_q <= full_d;
  end

  assign ctl_o.valid = vld_q[DEPTH-1];
  assign ctl_o.deg   = side_q[DEPTH-1][0];
  assign tag_o       = side_q[DEPTH-1][SDW-1:4];
  assign unit_o      = unit_q;
  assign full_o      = full_q;

  a_scaled_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_SQ] && !side_q[P_SQ][0] |->
      (nm_q[0][0][NORM_W-1] || nm_q[0][1][NORM_W-1] || nm_q[0][2][NORM_W-1]))
    else $error("scaled vector lost its leading one");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_OUT-1] && !side_q[P_OUT-1][0] |->
      (dl_q[QW-1][ROOT_W-1:NORM_W-1] != '0))
    else $error("vector length below the scaled range");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.valid && !ctl_o.deg |->
      ($signed(full_o[0]) <= UNIT_P && $signed(full_o[0]) >= UNIT_N &&
       $signed(full_o[1]) <= UNIT_P && $signed(full_o[1]) >= UNIT_N &&
       $signed(full_o[2]) <= UNIT_P && $signed(full_o[2]) >= UNIT_N))
    else $error("normalized component exceeds one");

endmodule

// ----- hdl/orthonormal_basis_from_vector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_basis_from_vector_top
// Builds a left and an up unit vector perpendicular to a forward vector.
// ----------------------------------------------------------------------------
// Usage:
// A forward vector on fwd_i is taken at a rising edge where start is high and
// busy is low. busy never rises, so one vector can be started every cycle.
// Each transfer gives exactly one result on res_o, shown for one cycle with
// done_o high; the receiver takes it at the edge ending that cycle and cannot
// hold it off, so nothing in the block waits on the receiver.
// A vector passes the input register, the first normalizer, the two cross
// product stages, the second normalizer and the output register. Each
// normalizer holds shift stages, a square root stage per root bit and a
// divide stage per quotient bit.
// Throughput is one vector per cycle.
// The collinear limit is written over its own valid/ready channel; ready is
// always high. Write it only while no vector is in flight.
// Reset clears every valid bit in the pipeline, so in-flight work is dropped,
// and loads the limit with 0.99999 in the fixed-point format.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_vector_top import obfv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fwd_t               fwd_i,
  output logic               done_o,
  output basis_t             res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  // Width of the exact cross product of the forward vector and a unit vector.
  localparam int CW      = FRAC_BITS + 26;
  localparam int TW1     = 3 * IN_W + 1;
  localparam int TW2     = 3 * OUT_W + 2;
  localparam int LATENCY = norm_depth(RAW_W, FRAC_BITS) + norm_depth(CW, FRAC_BITS) + 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST =
    LIMIT_W'(((longint'(1) << FRAC_BITS) * 99999 + 50000) / 100000);

  logic [LIMIT_W-1:0]        limit_q;
  logic                      accept;
  logic [IN_W-1:0]           absz;
  logic                      yref_d;
  logic [2:0][RAW_W-1:0]     raw1_d, raw1_q;
  fwd_t                      iv_q;
  logic                      yref_q;
  logic                      in_vld_q;

  norm_ctl_t                 ctl1, ctl2;
  logic [TW1-1:0]            tag1;
  logic [TW2-1:0]            tag2;
  logic [2:0][OUT_W-1:0]     unit1, unit2;
  logic [2:0][FRAC_BITS+1:0] full1, full2;
  fwd_t                      iv1;

  logic signed [CW-1:0]      prod_q [6];
  logic [2:0][OUT_W-1:0]     x1_unit_q, x2_unit_q;
  logic                      x1_yref_q, x2_yref_q, x1_deg_q, x2_deg_q;
  logic                      x1_vld_q, x2_vld_q;
  logic signed [CW-1:0]      diff [3];
  logic [2:0][CW-1:0]        raw2_d, raw2_q;

  logic [2:0][OUT_W-1:0]     u1;
  basis_t                    res_d, res_q;
  logic                      done_q;

  // The pipeline never stalls: a new vector is welcome on every cycle.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Input stage: branch choice and the first vector to normalize.
  // Z branch takes (-y, x, 0), the Y branch takes (-z, 0, x).
  always_comb begin
    absz   = fwd_i.fwd_z[IN_W-1] ? IN_W'(-fwd_i.fwd_z) : IN_W'(fwd_i.fwd_z);
    yref_d = (absz >= IN_W'(limit_q));
    if (yref_d) begin
      raw1_d[0] = -(RAW_W'(fwd_i.fwd_z));
      raw1_d[1] = '0;
      raw1_d[2] = RAW_W'(fwd_i.fwd_x);
    end else begin
      raw1_d[0] = -(RAW_W'(fwd_i.fwd_y));
      raw1_d[1] = RAW_W'(fwd_i.fwd_x);
      raw1_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    raw1_q <= raw1_d;
    iv_q   <= fwd_i;
    yref_q <= yref_d;
  end

  // First normalization: the forward vector and branch ride along as tag.
  obfv_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (RAW_W),
    .TW        (TW1)
  ) u_norm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .vec_i   (raw1_q),
    .tag_i   ({iv_q, yref_q}),
    .ctl_o   (ctl1),
    .tag_o   (tag1),
    .unit_o  (unit1),
    .full_o  (full1)
  );

  assign iv1 = fwd_t'(tag1[TW1-1:1]);

  // Cross product stage one: the six products of i x n1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
    end else begin
      x1_vld_q <= ctl1.valid;
      x2_vld_q <= x1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0] <= CW'(iv1.fwd_y) * CW'($signed(full1[2]));
    prod_q[1] <= CW'(iv1.fwd_z) * CW'($signed(full1[1]));
    prod_q[2] <= CW'(iv1.fwd_z) * CW'($signed(full1[0]));
    prod_q[3] <= CW'(iv1.fwd_x) * CW'($signed(full1[2]));
    prod_q[4] <= CW'(iv1.fwd_x) * CW'($signed(full1[1]));
    prod_q[5] <= CW'(iv1.fwd_y) * CW'($signed(full1[0]));
    x1_unit_q <= unit1;
    x1_yref_q <= tag1[0];
    x1_deg_q  <= ctl1.deg;
  end

  // Cross product stage two. In the Y branch the vector wanted is k x i,
  // which is the negated i x k.
  always_comb begin
    diff[0] = prod_q[0] - prod_q[1];
    diff[1] = prod_q[2] - prod_q[3];
    diff[2] = prod_q[4] - prod_q[5];
    for (int c = 0; c < 3; c++) begin
      raw2_d[c] = x1_yref_q ? -diff[c] : diff[c];
    end
  end

  always_ff @(posedge clk_i) begin
    raw2_q    <= raw2_d;
    x2_unit_q <= x1_unit_q;
    x2_yref_q <= x1_yref_q;
    x2_deg_q  <= x1_deg_q;
  end

  // Second normalization: the first unit vector rides along as tag.
  obfv_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (CW),
    .TW        (TW2)
  ) u_norm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2_vld_q),
    .vec_i   (raw2_q),
    .tag_i   ({x2_unit_q, x2_yref_q, x2_deg_q}),
    .ctl_o   (ctl2),
    .tag_o   (tag2),
    .unit_o  (unit2),
    .full_o  (full2)
  );

  assign u1 = tag2[TW2-1:2];

  // Output stage: route the two unit vectors to left and up by branch.
  always_comb begin
    if (tag2[1]) begin
      res_d.up_x   = u1[0];
      res_d.up_y   = u1[1];
      res_d.up_z   = u1[2];
      res_d.left_x = unit2[0];
      res_d.left_y = unit2[1];
      res_d.left_z = unit2[2];
    end else begin
      res_d.left_x = u1[0];
      res_d.left_y = u1[1];
      res_d.left_z = u1[2];
      res_d.up_x   = unit2[0];
      res_d.up_y   = unit2[1];
      res_d.up_z   = unit2[2];
    end
    res_d.used_y_reference = tag2[1];
    res_d.degenerate       = tag2[0] || ctl2.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl2.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // A result strobe must trace back to a transfer exactly one latency ago.
  a_done_traced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY + 1))
    else $error("result strobe without a matching start");

  // The Z branch left vector lies in the x-y plane.
  a_left_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.used_y_reference |-> res_o.left_z == '0)
    else $error("left vector has a z component in the Z branch");

  // The Y branch up vector lies in the x-z plane.
  a_up_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.used_y_reference |-> res_o.up_y == '0)
    else $error("up vector has a y component in the Y branch");

endmodule
